// ----- src/tld_pkg.sv -----
// Package: constants, types and command codes for the tree label distance query core.
package tld_pkg;
    localparam int NODE_COUNT      = 4096;
    localparam int EULER_LEN       = 8192;
    localparam int SPARSE_LEVELS   = 13;
    localparam int MAX_TREE_HEIGHT = 64;
    localparam int MAX_SEPARATORS  = 32;

    localparam int NODE_W  = 12;
    localparam int EPOS_W  = 13;
    localparam int LVL_W   = 4;
    localparam int SLOT_W  = 6;
    localparam int SEP_W   = 5;
    localparam int LABEL_W = 30;
    localparam int DIST_W  = 31;

    localparam int SPARSE_DEPTH = SPARSE_LEVELS * EULER_LEN;
    localparam int SPARSE_AW    = $clog2(SPARSE_DEPTH);
    localparam int LABEL_DEPTH  = NODE_COUNT * MAX_TREE_HEIGHT;
    localparam int LABEL_AW     = $clog2(LABEL_DEPTH);
    localparam int SEPP_DEPTH   = NODE_COUNT * MAX_SEPARATORS;
    localparam int SEPP_AW      = $clog2(SEPP_DEPTH);

    localparam logic [DIST_W-1:0] UNREACH_RESET = 31'd999999999;

    typedef enum logic [3:0] {
        CMD_QUERY     = 4'd0,
        CMD_TREE      = 4'd1,
        CMD_EULER     = 4'd2,
        CMD_HEIGHT    = 4'd3,
        CMD_SPARSE    = 4'd4,
        CMD_SELF      = 4'd5,
        CMD_LABEL     = 4'd6,
        CMD_SEP_POS   = 4'd7,
        CMD_SEP_COUNT = 4'd8
    } cmd_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_TREE,
        ST_TREE_W,
        ST_EPOS,
        ST_EPOS_W,
        ST_SPAN,
        ST_SPARSE_W,
        ST_SPARSE_R,
        ST_DEPTH_W,
        ST_DEPTH_R,
        ST_DECIDE,
        ST_SELF_W,
        ST_ANC_LABEL,
        ST_ANC_W,
        ST_CNT_W,
        ST_SEP_RD,
        ST_SEP_W,
        ST_LBL_X,
        ST_LBL_Y,
        ST_LBL_XW,
        ST_SUM,
        ST_DONE
    } state_t;
endpackage

// ----- src/tld_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read.
module tld_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ----- src/tree_label_distance_query_core.sv -----
// Top level: H2H two-hop distance query engine over preloaded index tables.
//
//   channel | signals                                         | notes
//   cmd in  | start/busy, cmd index_a index_b value query_src query_dst | taken when start & !busy
//   result  | result_valid, distance none_found                | one-cycle strobe per query
//   config  | APB psel penable pwrite paddr pwdata prdata pready | reg 0 unreachable_value
//
// A table write is accepted, then holds busy in the done state while the RAM is written.
// A query's busy time is set by the dependent registered-read RAM chain and the one shared
// add/compare unit, and on the separator path grows with the separator count (at most 32);
// the result strobe follows in the next cycle.
// Equal-node queries go straight to the done state. Reset clears control state and the register only;
// table contents are undefined until written. The result strobe cannot be stalled.
module tree_label_distance_query_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [3:0]                      cmd,
    input  logic [12:0]                     index_a,
    input  logic [5:0]                      index_b,
    input  logic [29:0]                     value,
    input  logic [11:0]                     query_src,
    input  logic [11:0]                     query_dst,
    output logic                            result_valid,
    output logic [30:0]                     distance,
    output logic                            none_found,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [1:0]                      paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    import tld_pkg::*;

    state_t state_reg, state_next;
    logic [DIST_W-1:0] unreach_reg;

    // latched command beat
    logic [3:0]         cmd_reg;
    logic [12:0]        a_reg;
    logic [5:0]         b_reg;
    logic [29:0]        v_reg;
    logic [NODE_W-1:0]  src_reg, dst_reg;

    logic [NODE_W-1:0]  x_reg, x_next, y_reg, y_next;
    logic [EPOS_W-1:0]  lo_reg, lo_next, hi_reg, hi_next;
    logic [LVL_W-1:0]   k_reg, k_next;
    logic [NODE_W-1:0]  cl_reg, cl_next, cr_reg, cr_next, lca_reg, lca_next;
    logic [SLOT_W-1:0]  dl_reg, dl_next;
    logic [5:0]         cnt_reg, cnt_next;
    logic [SEP_W-1:0]   i_reg, i_next;
    logic [SLOT_W-1:0]  slot_reg, slot_next;
    logic [LABEL_W-1:0] lx_reg, lx_next;
    logic [31:0]        best_reg, best_next;
    logic               none_reg, none_next;
    logic               rv_reg, rv_next;
    logic [DIST_W-1:0]  dist_reg, dist_next;
    logic               nf_reg, nf_next;

    logic accept;
    assign accept = start && (state_reg == ST_IDLE);
    assign busy = (state_reg != ST_IDLE);

    // write side (only in cycle after accept)
    logic wr_phase;
    assign wr_phase = (state_reg == ST_DONE) && (cmd_reg != CMD_QUERY);

    // RAMs
    logic [NODE_W-1:0]  tree_ra;  logic [NODE_W-1:0]  tree_rd;
    logic [NODE_W-1:0]  epos_ra;  logic [EPOS_W-1:0]  epos_rd;
    logic [NODE_W-1:0]  dep_ra;   logic [SLOT_W-1:0]  dep_rd;
    logic [SPARSE_AW-1:0] sp_ra;  logic [NODE_W-1:0]  sp_rd;
    logic [NODE_W-1:0]  self_ra;  logic [SLOT_W-1:0]  self_rd;
    logic [LABEL_AW-1:0] lb_ra;   logic [LABEL_W-1:0] lb_rd;
    logic [SEPP_AW-1:0] spp_ra;   logic [SLOT_W-1:0]  spp_rd;
    logic [NODE_W-1:0]  scnt_ra;  logic [5:0]         scnt_rd;

    logic a_node_ok;
    assign a_node_ok = (a_reg < 13'(NODE_COUNT));

    logic [SPARSE_AW-1:0] sp_wa;
    logic [LABEL_AW-1:0]  lb_wa;
    logic [SEPP_AW-1:0]   spp_wa;
    assign sp_wa  = SPARSE_AW'(b_reg) * SPARSE_AW'(EULER_LEN) + SPARSE_AW'(a_reg);
    assign lb_wa  = {a_reg[NODE_W-1:0], b_reg};
    assign spp_wa = {a_reg[NODE_W-1:0], b_reg[SEP_W-1:0]};

    tld_ram #(.WIDTH(NODE_W), .DEPTH(NODE_COUNT)) u_tree (.clk(clk),
        .we(wr_phase && cmd_reg == CMD_TREE && a_node_ok), .waddr(a_reg[NODE_W-1:0]),
        .wdata(v_reg[NODE_W-1:0]), .raddr(tree_ra), .rdata(tree_rd));
    tld_ram #(.WIDTH(EPOS_W), .DEPTH(NODE_COUNT)) u_epos (.clk(clk),
        .we(wr_phase && cmd_reg == CMD_EULER && a_node_ok), .waddr(a_reg[NODE_W-1:0]),
        .wdata(v_reg[EPOS_W-1:0]), .raddr(epos_ra), .rdata(epos_rd));
    tld_ram #(.WIDTH(SLOT_W), .DEPTH(NODE_COUNT)) u_dep (.clk(clk),
        .we(wr_phase && cmd_reg == CMD_HEIGHT && a_node_ok), .waddr(a_reg[NODE_W-1:0]),
        .wdata(v_reg[SLOT_W-1:0]), .raddr(dep_ra), .rdata(dep_rd));
    tld_ram #(.WIDTH(NODE_W), .DEPTH(SPARSE_DEPTH)) u_sparse (.clk(clk),
        .we(wr_phase && cmd_reg == CMD_SPARSE && b_reg < 6'(SPARSE_LEVELS)),
        .waddr(sp_wa), .wdata(v_reg[NODE_W-1:0]), .raddr(sp_ra), .rdata(sp_rd));
    tld_ram #(.WIDTH(SLOT_W), .DEPTH(NODE_COUNT)) u_self (.clk(clk),
        .we(wr_phase && cmd_reg == CMD_SELF && a_node_ok), .waddr(a_reg[NODE_W-1:0]),
        .wdata(v_reg[SLOT_W-1:0]), .raddr(self_ra), .rdata(self_rd));
    tld_ram #(.WIDTH(LABEL_W), .DEPTH(LABEL_DEPTH)) u_label (.clk(clk),
        .we(wr_phase && cmd_reg == CMD_LABEL && a_node_ok), .waddr(lb_wa),
        .wdata(v_reg), .raddr(lb_ra), .rdata(lb_rd));
    tld_ram #(.WIDTH(SLOT_W), .DEPTH(SEPP_DEPTH)) u_sepp (.clk(clk),
        .we(wr_phase && cmd_reg == CMD_SEP_POS && a_node_ok && b_reg < 6'(MAX_SEPARATORS)),
        .waddr(spp_wa), .wdata(v_reg[SLOT_W-1:0]), .raddr(spp_ra), .rdata(spp_rd));
    tld_ram #(.WIDTH(6), .DEPTH(NODE_COUNT)) u_scnt (.clk(clk),
        .we(wr_phase && cmd_reg == CMD_SEP_COUNT && a_node_ok), .waddr(a_reg[NODE_W-1:0]),
        .wdata(v_reg[5:0]), .raddr(scnt_ra), .rdata(scnt_rd));

    // span level from length: k=0 for len<=2, else ceil(log2 len)-1 = floor(log2(len-1))
    logic [EPOS_W-1:0] diff;
    logic [LVL_W-1:0]  k_calc;
    assign diff = hi_reg - lo_reg; // len-1
    always_comb
    begin
        k_calc = '0;
        for (int j = 1; j < EPOS_W; j++)
        begin
            if (diff[j])
            begin
                k_calc = LVL_W'(j);
            end
        end
    end

    logic [EPOS_W-1:0] right_pos;
    assign right_pos = hi_reg - ((EPOS_W'(1) << k_reg) - EPOS_W'(1));

    // shared adder/comparator
    logic [31:0] sum;
    logic        less;
    assign sum  = 32'(lx_reg) + 32'(lb_rd);
    assign less = sum < best_reg;

    logic [NODE_W-1:0] anc, des;
    assign anc = (lca_reg == y_reg) ? y_reg : x_reg;
    assign des = (lca_reg == y_reg) ? x_reg : y_reg;

    always_comb
    begin
        state_next = state_reg;
        x_next = x_reg; y_next = y_reg; lo_next = lo_reg; hi_next = hi_reg;
        k_next = k_reg; cl_next = cl_reg; cr_next = cr_reg; lca_next = lca_reg;
        dl_next = dl_reg; cnt_next = cnt_reg; i_next = i_reg; slot_next = slot_reg;
        lx_next = lx_reg; best_next = best_reg; none_next = none_reg;
        rv_next = 1'b0; dist_next = dist_reg; nf_next = nf_reg;
        tree_ra = src_reg; epos_ra = x_reg; dep_ra = cl_reg;
        sp_ra = SPARSE_AW'(k_reg) * SPARSE_AW'(EULER_LEN) + SPARSE_AW'(lo_reg);
        self_ra = anc; lb_ra = {des, self_rd};
        spp_ra = {lca_reg, i_reg}; scnt_ra = lca_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (cmd == CMD_QUERY && query_src != query_dst)
                    begin
                        state_next = ST_TREE;
                    end
                    else if (cmd == CMD_QUERY)
                    begin
                        best_next = 32'd0; none_next = 1'b0;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_TREE:     begin tree_ra = src_reg; state_next = ST_TREE_W; end
            ST_TREE_W:   begin x_next = tree_rd; tree_ra = dst_reg; state_next = ST_EPOS; end
            ST_EPOS:     begin y_next = tree_rd; epos_ra = x_reg; state_next = ST_EPOS_W; end
            ST_EPOS_W:   begin lo_next = epos_rd; epos_ra = y_reg; state_next = ST_SPAN; end
            ST_SPAN:
            begin
                if (lo_reg > epos_rd)
                begin
                    hi_next = lo_reg; lo_next = epos_rd;
                end
                else
                begin
                    hi_next = epos_rd;
                end
                state_next = ST_SPARSE_W;
            end
            ST_SPARSE_W:
            begin
                k_next = k_calc;
                state_next = ST_SPARSE_R;
            end
            ST_SPARSE_R:
            begin
                sp_ra = SPARSE_AW'(k_reg) * SPARSE_AW'(EULER_LEN) + SPARSE_AW'(lo_reg);
                state_next = ST_DEPTH_W;
            end
            ST_DEPTH_W:
            begin
                cl_next = sp_rd;
                sp_ra = SPARSE_AW'(k_reg) * SPARSE_AW'(EULER_LEN) + SPARSE_AW'(right_pos);
                state_next = ST_DEPTH_R;
            end
            ST_DEPTH_R:
            begin
                cr_next = sp_rd; dep_ra = cl_reg;
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                // capture left depth, issue right depth read
                dl_next = dep_rd; dep_ra = cr_reg;
                state_next = ST_SELF_W;
            end
            ST_SELF_W:
            begin
                lca_next = (dl_reg < dep_rd) ? cl_reg : cr_reg;
                state_next = ST_ANC_LABEL;
            end
            ST_ANC_LABEL:
            begin
                if (lca_reg == x_reg || lca_reg == y_reg)
                begin
                    self_ra = anc;
                    state_next = ST_ANC_W;
                end
                else
                begin
                    scnt_ra = lca_reg;
                    state_next = ST_CNT_W;
                end
            end
            ST_ANC_W:
            begin
                lb_ra = {des, self_rd};
                state_next = ST_LBL_XW;
                i_next = '0;
                cnt_next = 6'd0;
            end
            ST_LBL_XW:
            begin
                // ancestor label result
                best_next = 32'(lb_rd); none_next = 1'b0;
                state_next = ST_DONE;
            end
            ST_CNT_W:
            begin
                cnt_next = (scnt_rd > 6'(MAX_SEPARATORS)) ? 6'(MAX_SEPARATORS) : scnt_rd;
                best_next = 32'(unreach_reg);
                none_next = (scnt_rd == 6'd0);
                i_next = '0;
                state_next = (scnt_rd == 6'd0) ? ST_DONE : ST_SEP_RD;
            end
            ST_SEP_RD:   begin spp_ra = {lca_reg, i_reg}; state_next = ST_SEP_W; end
            ST_SEP_W:
            begin
                slot_next = spp_rd;
                lb_ra = {x_reg, spp_rd};
                state_next = ST_LBL_X;
            end
            ST_LBL_X:
            begin
                lx_next = lb_rd;
                lb_ra = {y_reg, slot_reg};
                state_next = ST_LBL_Y;
            end
            ST_LBL_Y:
            begin
                lb_ra = {y_reg, slot_reg};
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                if (less)
                begin
                    best_next = sum;
                end
                if (6'(i_reg) + 6'd1 >= cnt_reg)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    i_next = i_reg + SEP_W'(1);
                    state_next = ST_SEP_RD;
                end
            end
            ST_DONE:
            begin
                if (cmd_reg == CMD_QUERY)
                begin
                    rv_next = 1'b1;
                    dist_next = best_reg[31] ? {DIST_W{1'b1}} : best_reg[DIST_W-1:0];
                    nf_next = none_reg;
                end
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            rv_reg <= 1'b0;
            unreach_reg <= UNREACH_RESET;
        end
        else
        begin
            state_reg <= state_next;
            rv_reg <= rv_next;
            if (psel && penable && pwrite && paddr == 2'd0)
            begin
                unreach_reg <= pwdata[DIST_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd; a_reg <= index_a; b_reg <= index_b; v_reg <= value;
            src_reg <= query_src; dst_reg <= query_dst;
        end
        x_reg <= x_next; y_reg <= y_next; lo_reg <= lo_next; hi_reg <= hi_next;
        k_reg <= k_next; cl_reg <= cl_next; cr_reg <= cr_next; lca_reg <= lca_next;
        dl_reg <= dl_next; cnt_reg <= cnt_next; i_reg <= i_next; slot_reg <= slot_next;
        lx_reg <= lx_next; best_reg <= best_next; none_reg <= none_next;
        dist_reg <= dist_next; nf_reg <= nf_next;
    end

    assign result_valid = rv_reg;
    assign distance     = dist_reg;
    assign none_found   = nf_reg;
    assign pready       = 1'b1;
    assign prdata       = (paddr == 2'd0) ? {1'b0, unreach_reg} : 32'd0;

    a_busy_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !busy)
        else $error("result strobe while busy");
    a_result_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("result strobe longer than one cycle");
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("accepted beat did not raise busy");
endmodule

// ----- verif/tree_label_distance_query_core_test.sv -----
// Testbench for tree_label_distance_query_core: table writes, distance queries, APB register.
module tree_label_distance_query_core_test;
    import tld_pkg::*;

    localparam logic [3:0] CMD_UNUSED_LO = 4'd9;
    localparam logic [3:0] CMD_UNUSED_HI = 4'd15;
    localparam logic [1:0] REG_UNREACH   = 2'd0;
    localparam int         STALL_LIMIT   = 5000;
    localparam int         N_POOL        = 6;
    localparam int         N_GRAPH       = 8;

    typedef struct packed {
        logic [30:0] dist_val;
        logic        none;
    } dist_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [3:0]  cmd = '0;
    logic [12:0] index_a = '0;
    logic [5:0]  index_b = '0;
    logic [29:0] value = '0;
    logic [11:0] query_src = '0;
    logic [11:0] query_dst = '0;
    logic        result_valid;
    logic [30:0] distance;
    logic        none_found;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [1:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    logic [29:0]  index_mem [int];
    logic [30:0]  unreach_reg;
    dist_result_t dist_pending [$];
    int           miss_key;
    int           mismatches = 0;
    int           stall_cycles = 0;
    int           items_sent = 0;
    bit           idle_on = 1'b1;
    int           tree_pool [N_POOL];
    int           graph_pool [N_GRAPH];
    int           euler_base;

    tree_label_distance_query_core dut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int tkey(cmd_t c, int addr);
        return (int'(c) << 20) | addr;
    endfunction

    function automatic bit rd(int key, output logic [29:0] v);
        if (index_mem.exists(key))
        begin
            v = index_mem[key];
            return 1'b1;
        end
        miss_key = key;
        v = '0;
        return 1'b0;
    endfunction

    // returns 0 and sets miss_key when an unwritten entry would be read
    function automatic bit predict_distance(int src, int dst, output dist_result_t r);
        logic [29:0] x, y, lo, hi, cl, cr, dl, dr, lca, anc, des, sp, cnt, slot, lx, ly;
        int          len, span, k;
        logic [31:0] best, sum;
        r = '0;
        if (src == dst)
            return 1'b1;
        if (!rd(tkey(CMD_TREE, src), x)) return 1'b0;
        if (!rd(tkey(CMD_TREE, dst), y)) return 1'b0;
        if (!rd(tkey(CMD_EULER, x), lo)) return 1'b0;
        if (!rd(tkey(CMD_EULER, y), hi)) return 1'b0;
        if (lo > hi)
        begin
            cl = lo;
            lo = hi;
            hi = cl;
        end
        len = hi - lo + 1;
        span = 1;
        k = 0;
        while (len > span * 2)
        begin
            span *= 2;
            k++;
        end
        if (!rd(tkey(CMD_SPARSE, k * EULER_LEN + lo), cl)) return 1'b0;
        if (!rd(tkey(CMD_SPARSE, k * EULER_LEN + hi - span + 1), cr)) return 1'b0;
        if (!rd(tkey(CMD_HEIGHT, cl), dl)) return 1'b0;
        if (!rd(tkey(CMD_HEIGHT, cr), dr)) return 1'b0;
        lca = (dl < dr) ? cl : cr;
        if (lca == x || lca == y)
        begin
            anc = (lca == y) ? y : x;
            des = (lca == y) ? x : y;
            if (!rd(tkey(CMD_SELF, anc), sp)) return 1'b0;
            if (!rd(tkey(CMD_LABEL, des * MAX_TREE_HEIGHT + sp), lx)) return 1'b0;
            r.dist_val = {1'b0, lx};
        end
        else
        begin
            if (!rd(tkey(CMD_SEP_COUNT, lca), cnt)) return 1'b0;
            if (cnt > MAX_SEPARATORS)
                cnt = 30'(MAX_SEPARATORS);
            best = {1'b0, unreach_reg};
            r.none = (cnt == 0);
            for (int i = 0; i < cnt; i++)
            begin
                if (!rd(tkey(CMD_SEP_POS, lca * MAX_SEPARATORS + i), slot)) return 1'b0;
                if (!rd(tkey(CMD_LABEL, x * MAX_TREE_HEIGHT + slot), lx)) return 1'b0;
                if (!rd(tkey(CMD_LABEL, y * MAX_TREE_HEIGHT + slot), ly)) return 1'b0;
                sum = 32'(lx) + 32'(ly);
                if (sum < best)
                    best = sum;
            end
            r.dist_val = (best > 32'h7FFF_FFFF) ? 31'h7FFF_FFFF : best[30:0];
        end
        return 1'b1;
    endfunction

    function automatic void store_word(logic [3:0] c, int a, int b, logic [29:0] v);
        case (c)
            CMD_TREE:      if (a < NODE_COUNT) index_mem[tkey(CMD_TREE, a)] = v[11:0];
            CMD_EULER:     if (a < NODE_COUNT) index_mem[tkey(CMD_EULER, a)] = v[12:0];
            CMD_HEIGHT:    if (a < NODE_COUNT) index_mem[tkey(CMD_HEIGHT, a)] = v[5:0];
            CMD_SPARSE:
                if (b < SPARSE_LEVELS && a < EULER_LEN)
                    index_mem[tkey(CMD_SPARSE, b * EULER_LEN + a)] = v[11:0];
            CMD_SELF:      if (a < NODE_COUNT) index_mem[tkey(CMD_SELF, a)] = v[5:0];
            CMD_LABEL:
                if (a < NODE_COUNT && b < MAX_TREE_HEIGHT)
                    index_mem[tkey(CMD_LABEL, a * MAX_TREE_HEIGHT + b)] = v;
            CMD_SEP_POS:
                if (a < NODE_COUNT && b < MAX_SEPARATORS)
                    index_mem[tkey(CMD_SEP_POS, a * MAX_SEPARATORS + b)] = v[5:0];
            CMD_SEP_COUNT: if (a < NODE_COUNT) index_mem[tkey(CMD_SEP_COUNT, a)] = v[5:0];
            default: ;
        endcase
    endfunction

    task automatic idle_burst();
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    task automatic send_beat(int c, int a, int b, logic [31:0] v, int src, int dst);
        dist_result_t r;
        idle_burst();
        start <= 1'b1;
        cmd <= c[3:0];
        index_a <= a[12:0];
        index_b <= b[5:0];
        value <= v[29:0];
        query_src <= src[11:0];
        query_dst <= dst[11:0];
        @(posedge clk);
        while (busy)
            @(posedge clk);
        items_sent++;
        if (c[3:0] == CMD_QUERY)
        begin
            void'(predict_distance(src, dst, r));
            dist_pending = {dist_pending, r};
        end
        else
            store_word(c[3:0], a, b, v[29:0]);
    endtask

    task automatic fill_entry(int key);
        cmd_t c;
        int   addr;
        c = cmd_t'(key >> 20);
        addr = key & 20'hFFFFF;
        case (c)
            CMD_TREE:
                send_beat(c, addr, $urandom, tree_pool[$urandom_range(0, N_POOL-1)] |
                          ($urandom & 32'h3FFF_F000), $urandom, $urandom);
            CMD_EULER:
                send_beat(c, addr, $urandom, ($urandom_range(0, 2) != 0) ?
                          euler_base + $urandom_range(0, 15) : $urandom_range(0, EULER_LEN-1),
                          $urandom, $urandom);
            CMD_HEIGHT:
                send_beat(c, addr, $urandom, $urandom_range(0, 3), $urandom, $urandom);
            CMD_SPARSE:
                send_beat(c, addr % EULER_LEN, addr / EULER_LEN,
                          tree_pool[$urandom_range(0, N_POOL-1)], $urandom, $urandom);
            CMD_SELF:
                send_beat(c, addr, $urandom, $urandom, $urandom, $urandom);
            CMD_LABEL:
                send_beat(c, addr / MAX_TREE_HEIGHT, addr % MAX_TREE_HEIGHT,
                          ($urandom_range(0, 9) == 0) ? 32'h3FFF_FFFF : $urandom,
                          $urandom, $urandom);
            CMD_SEP_POS:
                send_beat(c, addr / MAX_SEPARATORS, addr % MAX_SEPARATORS, $urandom,
                          $urandom, $urandom);
            default:
                send_beat(CMD_SEP_COUNT, addr, $urandom,
                          ($urandom_range(0, 7) == 0) ? $urandom_range(0, 63) :
                          $urandom_range(0, 6), $urandom, $urandom);
        endcase
    endtask

    task automatic ask_distance(int src, int dst);
        dist_result_t r;
        while (!predict_distance(src, dst, r))
            fill_entry(miss_key);
        send_beat(CMD_QUERY, $urandom, $urandom, $urandom, src, dst);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        @(posedge clk);
        while (dist_pending.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic apb_write(logic [1:0] addr, logic [31:0] data);
        wait_drained();
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == REG_UNREACH)
            unreach_reg = data[30:0];
        @(posedge clk);
    endtask

    task automatic new_world();
        euler_base = $urandom_range(0, EULER_LEN - 16);
        foreach (tree_pool[i])
            tree_pool[i] = $urandom_range(0, NODE_COUNT-1);
        foreach (graph_pool[i])
            graph_pool[i] = $urandom_range(0, NODE_COUNT-1);
    endtask

    task automatic test_directed();
        new_world();
        send_beat(CMD_TREE, 8191, 0, 32'h3FFF_FFFF, 0, 0);
        send_beat(CMD_SPARSE, 0, 13, 32'h3FFF_FFFF, 0, 0);
        send_beat(CMD_SPARSE, 8191, 63, 32'h3FFF_FFFF, 0, 0);
        send_beat(CMD_LABEL, 4096, 0, 32'h3FFF_FFFF, 0, 0);
        send_beat(CMD_SEP_POS, 0, 32, 32'h3FFF_FFFF, 0, 0);
        send_beat(CMD_SEP_POS, 4095, 63, 32'h3FFF_FFFF, 0, 0);
        send_beat(CMD_UNUSED_LO, 0, 0, 0, 0, 1);
        send_beat(CMD_UNUSED_HI, 8191, 63, 32'h3FFF_FFFF, 4095, 0);
        send_beat(CMD_QUERY, 8191, 63, 32'h3FFF_FFFF, 0, 0);
        send_beat(CMD_QUERY, 0, 0, 0, 4095, 4095);
        // separator count above capacity
        send_beat(CMD_TREE, 0, 0, tree_pool[0], 0, 0);
        send_beat(CMD_TREE, 4095, 0, tree_pool[1], 0, 0);
        send_beat(CMD_SEP_COUNT, tree_pool[2], 0, 63, 0, 0);
        ask_distance(0, 4095);
        ask_distance(4095, 0);
    endtask

    task automatic test_random(int n_items);
        int stop_at;
        int src, dst, pick;
        stop_at = items_sent + n_items;
        new_world();
        while (items_sent < stop_at)
        begin
            pick = $urandom_range(0, 19);
            src = ($urandom_range(0, 9) == 0) ? $urandom_range(0, NODE_COUNT-1) :
                  graph_pool[$urandom_range(0, N_GRAPH-1)];
            dst = ($urandom_range(0, 9) == 0) ? src :
                  ($urandom_range(0, 9) == 0) ? $urandom_range(0, NODE_COUNT-1) :
                  graph_pool[$urandom_range(0, N_GRAPH-1)];
            if (pick < 13)
                ask_distance(src, dst);
            else if (pick < 19)
                send_beat($urandom_range(1, 8), $urandom_range(0, 8191), $urandom_range(0, 63),
                          $urandom, $urandom, $urandom);
            else
                send_beat($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI), $urandom, $urandom,
                          $urandom, $urandom, $urandom);
        end
    endtask

    task automatic test_unreach_settings();
        apb_write(REG_UNREACH, 32'h0000_0000);
        test_random(150);
        apb_write(REG_UNREACH, 32'hFFFF_FFFF);
        test_random(150);
        apb_write(REG_UNREACH, $urandom);
        test_random(150);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            if (dist_pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: distance %0d none_found %0b",
                             distance, none_found);
            end
            else
            begin
                dist_result_t r;
                r = dist_pending.pop_front();
                if (distance !== r.dist_val || none_found !== r.none)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: distance exp %0d got %0d, none_found exp %0b got %0b",
                                 r.dist_val, distance, r.none, none_found);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || result_valid)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("tree_label_distance_query_core_test failed");
            $finish;
        end
    end

    initial
    begin
        unreach_reg = UNREACH_RESET;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(200);
        wait_drained();
        test_unreach_settings();
        apb_write(REG_UNREACH, 32'd999999999);
        idle_on = 1'b0;
        test_random(350);
        wait_drained();
        repeat (20) @(posedge clk);
        if (mismatches == 0 && dist_pending.size() == 0)
            $display("tree_label_distance_query_core_test passed");
        else
            $display("tree_label_distance_query_core_test failed");
        $finish;
    end
endmodule
